@@ design/itc_pkg.sv @@
// ----------------------------------------------------------------------------
// itc_pkg: shared types and constants for the radix-to-ASCII converter
// Digit width, character codes, radix limits and the digit-to-character map.
// ----------------------------------------------------------------------------
package itc_pkg;

    localparam int DIGIT_W = 5;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [CHAR_W-1:0]  CH_NUL      = 7'd0;
    localparam logic [CHAR_W-1:0]  CH_MINUS    = 7'd45;
    localparam logic [CHAR_W-1:0]  CH_ZERO     = 7'd48;
    localparam logic [CHAR_W-1:0]  CH_LETTER_A = 7'd65;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 5'd10;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd32;
    localparam logic [RADIX_W-1:0] RADIX_TEN = 6'd10;

    typedef logic [DIGIT_W-1:0] digit_t;

    // status of the serial divider toward the sequencer
    typedef struct packed {
        logic   done;
        digit_t remainder;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input digit_t d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d >= DIGIT_TEN)
            return CH_LETTER_A + dx - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
        else
            return CH_ZERO + dx;
    endfunction

endpackage

@@ design/itc_serial_div.sv @@
// ----------------------------------------------------------------------------
// itc_serial_div: bit-serial restoring divider
// Divides a W-bit value by a radix of 2..32, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itc_serial_div #(
    parameter int W = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [W-1:0]               dividend,
    input  logic [itc_pkg::RADIX_W-1:0] divisor,
    output logic [W-1:0]               quotient,
    output itc_pkg::div_stat_t         stat
);

    localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]               q_reg, q_next;
    itc_pkg::digit_t            r_reg, r_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [itc_pkg::RADIX_W-1:0] trial;
    logic [itc_pkg::RADIX_W-1:0] diff;

    // remainder stays below the divisor (<= 31), so it fits the digit width
    assign trial = {r_reg, q_reg[W-1]};
    assign diff  = trial - divisor;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            if (trial >= divisor)
            begin
                r_next = diff[itc_pkg::DIGIT_W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[itc_pkg::DIGIT_W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign quotient       = q_reg;
    assign stat.done      = done_reg;
    assign stat.remainder = r_reg;

endmodule

@@ design/itc_digit_ram.sv @@
// ----------------------------------------------------------------------------
// itc_digit_ram: digit store
// One write port, one registered read port, W entries of one digit each.
// ----------------------------------------------------------------------------
module itc_digit_ram #(
    parameter int W = 32
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [((W > 1) ? $clog2(W) : 1)-1:0] wr_addr,
    input  itc_pkg::digit_t                     wr_data,
    input  logic                                rd_en,
    input  logic [((W > 1) ? $clog2(W) : 1)-1:0] rd_addr,
    output itc_pkg::digit_t                     rd_data
);

    itc_pkg::digit_t mem [W];
    itc_pkg::digit_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/integer_to_radix_ascii_core.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core: signed integer to ASCII digits in radix 2..32
// Digits are found least significant first by a serial divider, kept in a
// small store, then sent most significant first, one character per item.
// ----------------------------------------------------------------------------
//  channel | signals                                   | carries
//  --------+-------------------------------------------+------------------------
//  in      | in_valid, in_ready, number, radix         | value and base
//  out     | out_valid, out_ready, character,          | one character, end mark,
//          | last_char, bad_radix                      | base error flag
//
//  Each digit takes one pass of the bit-serial divider; each character then
//  passes through store read, load and show, plus any stall. A bad base
//  skips the divider and gives a single error item.
//  in_ready is high only between conversions; one item is in work at a time.
//  out_ready low holds the current character; reset clears all control state.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [VALUE_WIDTH-1:0]        number,
    input  logic [itc_pkg::RADIX_W-1:0]          radix,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [itc_pkg::CHAR_W-1:0]           character,
    output logic                                 last_char,
    output logic                                 bad_radix
);

    localparam int AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_SHOW = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [VALUE_WIDTH-1:0]      mag_reg, mag_next;
    logic [CW-1:0]               n_reg, n_next;
    logic                        neg10_reg, neg10_next;
    logic [itc_pkg::RADIX_W-1:0] radix_reg, radix_next;
    logic [itc_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                        last_reg, last_next;
    logic                        bad_reg, bad_next;

    logic                        accept;
    logic                        out_take;
    logic                        neg_in;
    logic                        radix_ok;
    logic [VALUE_WIDTH-1:0]      mag_in;
    logic [CW-1:0]               n_inc;
    logic [CW-1:0]               n_dec;

    logic                        div_start;
    logic [VALUE_WIDTH-1:0]      div_dividend;
    logic [VALUE_WIDTH-1:0]      div_quot;
    itc_pkg::div_stat_t          div_stat;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    itc_pkg::digit_t             wr_data;
    logic                        rd_en;
    itc_pkg::digit_t             rd_data;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_HOLD);
    assign accept    = in_valid && in_ready;
    assign out_take  = out_valid && out_ready;

    assign neg_in   = number[VALUE_WIDTH-1];
    assign mag_in   = neg_in ? (~number + 1'b1) : number;
    assign radix_ok = (radix >= itc_pkg::RADIX_MIN) && (radix <= itc_pkg::RADIX_MAX);
    assign n_inc    = n_reg + 1'b1;
    assign n_dec    = n_reg - 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        n_next       = n_reg;
        neg10_next   = neg10_reg;
        radix_next   = radix_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        bad_next     = bad_reg;
        div_start    = 1'b0;
        div_dividend = mag_in;
        wr_en        = 1'b0;
        wr_addr      = n_reg[AW-1:0];
        wr_data      = div_stat.remainder;
        rd_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!radix_ok)
                    begin
                        char_next  = itc_pkg::CH_NUL;
                        last_next  = 1'b1;
                        bad_next   = 1'b1;
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        radix_next = radix;
                        mag_next   = mag_in;
                        neg10_next = neg_in && (radix == itc_pkg::RADIX_TEN);
                        bad_next   = 1'b0;
                        if (mag_in == '0)
                        begin
                            // zero converts to a single '0' digit
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = '0;
                            n_next     = CW'(1);
                            state_next = ST_READ;
                        end
                        else
                        begin
                            n_next     = '0;
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                div_dividend = div_quot;
                if (div_stat.done)
                begin
                    wr_en    = 1'b1;
                    n_next   = n_inc;
                    mag_next = div_quot;
                    if ((div_quot == '0) || (n_inc == CW'(VALUE_WIDTH)))
                    begin
                        if (neg10_reg)
                        begin
                            char_next  = itc_pkg::CH_MINUS;
                            last_next  = 1'b0;
                            state_next = ST_HOLD;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                n_next     = n_dec;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                char_next  = itc_pkg::digit_to_ascii(rd_data);
                last_next  = (n_reg == '0);
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_take)
                    state_next = last_reg ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mag_reg   <= '0;
            n_reg     <= '0;
            neg10_reg <= 1'b0;
            last_reg  <= 1'b0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mag_reg   <= mag_next;
            n_reg     <= n_next;
            neg10_reg <= neg10_next;
            last_reg  <= last_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        char_reg  <= char_next;
    end

    itc_serial_div #(
        .W (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  ((state_reg == ST_IDLE) ? radix : radix_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    itc_digit_ram #(
        .W (VALUE_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (n_dec[AW-1:0]),
        .rd_data (rd_data)
    );

    assign character = char_reg;
    assign last_char = last_reg;
    assign bad_radix = bad_reg;

endmodule

@@ design/itc_checker.sv @@
// ----------------------------------------------------------------------------
// itc_checker: port-level checks for the radix-to-ASCII converter
// Watches the handshakes and result flags seen at the top level.
// ----------------------------------------------------------------------------
module itc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [itc_pkg::CHAR_W-1:0]   character,
    input logic                         last_char,
    input logic                         bad_radix
);

    // a stalled character must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(character)
            && $stable(last_char) && $stable(bad_radix))
        else $error("output item changed while stalled");

    // one conversion at a time: no new item right after one is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    // no results are shown while waiting for a new item
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("output valid while idle");

    // base error is a single NUL item that ends the run
    a_bad_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_radix |-> last_char && (character == itc_pkg::CH_NUL))
        else $error("malformed base error item");

endmodule

bind integer_to_radix_ascii_core itc_checker u_itc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last_char (last_char),
    .bad_radix (bad_radix)
);
